// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// When ante holds, cons must hold at the next clock edge.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mvr_pkg.sv
// Types, constants and angle helper functions of the motion vector rotator.
package mvr_pkg;

  localparam int unsigned MotionBits = 16;
  localparam int unsigned AngleArgW  = 11;
  localparam int unsigned AngleW     = 9;
  localparam int unsigned AngleSumW  = 12;
  localparam int unsigned TrigW      = 11;
  localparam int unsigned MotionOutW = 17;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 9;

  // Product and sum widths of the rotation terms.
  localparam int unsigned ProdW = MotionBits + TrigW;
  localparam int unsigned SumW  = ProdW + 1;
  // Magnitude of a sum stays below 2^(MotionBits-1) * 2048.
  localparam int unsigned MagW  = MotionBits + 10;
  // Reciprocal of 1000, scaled so that the quotient is exact over MagW bits.
  localparam int unsigned RecShift = MagW + 10;
  localparam int unsigned RecW     = RecShift - 9;
  localparam int unsigned QuotW    = MagW + RecW - RecShift;
  localparam longint unsigned RecipK = ((64'd1 << RecShift) + 64'd999) / 64'd1000;

  localparam logic [AngleW-1:0] FullTurn    = 9'd360;
  localparam logic [AngleW-1:0] StepMaxInit = 9'd359;

  typedef enum logic [1:0] {
    FuncMoveX     = 2'd0,
    FuncMoveY     = 2'd1,
    FuncSetAngle  = 2'd2,
    FuncStepAngle = 2'd3
  } func_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgStepMin    = 2'd0,
    CfgStepMax    = 2'd1,
    CfgWrapEnable = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TrigW-1:0] sin_v;
    logic signed [TrigW-1:0] cos_v;
  } trig_t;

  // Sine of 0..90 degrees in 5-degree steps, scaled by 1000.
  localparam logic signed [TrigW-1:0] SinTab [19] = '{
    11'sd0,   11'sd87,  11'sd174, 11'sd259, 11'sd342, 11'sd423, 11'sd500,
    11'sd574, 11'sd643, 11'sd707, 11'sd766, 11'sd819, 11'sd866, 11'sd906,
    11'sd940, 11'sd966, 11'sd985, 11'sd996, 11'sd1000
  };

  // Reduces an angle in -1080..1439 to 0..359; the candidates are independent.
  function automatic logic [AngleW-1:0] fold360(input logic signed [AngleSumW-1:0] a);
    logic signed [AngleSumW+1:0] cand;
    logic [AngleW-1:0]           r;
    r = '0;
    for (int k = -3; k <= 3; k++) begin
      cand = (AngleSumW+2)'(a) - (AngleSumW+2)'(k * 360);
      if (cand >= 0 && cand < 360) begin
        r = cand[AngleW-1:0];
      end
    end
    return r;
  endfunction

  // Sine and cosine of an angle in 0..359, truncated to a multiple of 5 degrees.
  function automatic trig_t trig_of(input logic [AngleW-1:0] a);
    logic [1:0]              quad;
    logic [6:0]              rem;
    logic [14:0]             scaled;
    logic [4:0]              idx;
    logic signed [TrigW-1:0] sb;
    logic signed [TrigW-1:0] cb;
    trig_t                   t;
    if (a >= 9'd270) begin
      quad = 2'd3;
      rem  = 7'(a - 9'd270);
    end else if (a >= 9'd180) begin
      quad = 2'd2;
      rem  = 7'(a - 9'd180);
    end else if (a >= 9'd90) begin
      quad = 2'd1;
      rem  = 7'(a - 9'd90);
    end else begin
      quad = 2'd0;
      rem  = a[6:0];
    end
    // rem / 5 for rem below 90, by multiplying with 205 / 1024.
    scaled = 15'(rem) * 15'd205;
    idx    = scaled[14:10];
    sb     = SinTab[idx];
    cb     = SinTab[5'd18 - idx];
    case (quad)
      2'd0: begin
        t.sin_v = sb;
        t.cos_v = cb;
      end
      2'd1: begin
        t.sin_v = cb;
        t.cos_v = -sb;
      end
      2'd2: begin
        t.sin_v = -sb;
        t.cos_v = -cb;
      end
      default: begin
        t.sin_v = -cb;
        t.cos_v = sb;
      end
    endcase
    return t;
  endfunction

endpackage

// File: src/motion_vector_rotator_core.sv
// Motion vector rotator: rotates relative X/Y pointer motion by a stored angle.
//
// Input requests carry func_i, motion_i and angle_arg_i and are taken when
// in_valid_i is high and in_stall_o is low. X and Y requests are rotated with
// the last stored value of the other component; set and step requests change
// the angle and return a zero motion value. Every request gives exactly one
// result on out_valid_o / motion_out_o / angle_now_o, taken when out_stall_i
// is low.
// One request per cycle is sustained while out_stall_i is low: the angle and
// state update and the two rotation products sit between the input register
// and the middle register, and the divide by 1000 (a reciprocal multiply)
// between the middle register and the result register.
// When out_stall_i is held the result stays on the outputs and the pipeline
// fills; in_stall_o rises once all three stages hold a request.
// The limit registers must be written by the user through cfg_valid_i /
// cfg_index_i / cfg_data_i only while no request is in flight; the block
// does not enforce this. cfg_ready_o is always high.
// Reset empties the pipeline, sets the angle to 0, the stored components to
// 0, the step limits to 0 and 359 and selects clamping.
module motion_vector_rotator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            func_i,
  input  logic signed [mvr_pkg::MotionBits-1:0] motion_i,
  input  logic signed [mvr_pkg::AngleArgW-1:0]  angle_arg_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mvr_pkg::MotionOutW-1:0] motion_out_o,
  output logic [mvr_pkg::AngleW-1:0]            angle_now_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mvr_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [mvr_pkg::CfgDataW-1:0]          cfg_data_i
);
  import mvr_pkg::*;

  localparam logic [RecW-1:0] RecipKW = RecW'(RecipK);

  // Configuration
  logic [AngleW-1:0] step_min_q;
  logic [AngleW-1:0] step_max_q;
  logic              wrap_q;

  // Architectural state
  logic signed [MotionBits-1:0] last_x_q;
  logic signed [MotionBits-1:0] last_y_q;
  logic [AngleW-1:0]            angle_q;
  logic signed [TrigW-1:0]      sin_q;
  logic signed [TrigW-1:0]      cos_q;

  // Stage 1: accepted request
  logic                         s1_valid_q;
  func_e                        s1_func_q;
  logic signed [MotionBits-1:0] s1_motion_q;
  logic signed [AngleArgW-1:0]  s1_arg_q;

  // Stage 2: rotation sum
  logic                   s2_valid_q;
  logic signed [SumW-1:0] s2_sum_q;
  logic signed [SumW-1:0] s2_sum_d;
  logic [AngleW-1:0]      s2_angle_q;
  logic [AngleW-1:0]      s2_angle_d;

  // Stage 3: result
  logic                         out_valid_q;
  logic signed [MotionOutW-1:0] motion_out_q;
  logic signed [MotionOutW-1:0] motion_out_d;
  logic [AngleW-1:0]            angle_now_q;

  logic s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv, in_fire;

  assign s3_free = ~out_valid_q | ~out_stall_i;
  assign s2_free = ~s2_valid_q | s3_free;
  assign s1_free = ~s1_valid_q | s2_free;
  assign s2_adv  = s2_valid_q & s3_free;
  assign s1_adv  = s1_valid_q & s2_free;
  assign in_fire = in_valid_i & s1_free;

  assign in_stall_o   = ~s1_free;
  assign out_valid_o  = out_valid_q;
  assign motion_out_o = motion_out_q;
  assign angle_now_o  = angle_now_q;
  assign cfg_ready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_min_q <= '0;
      step_max_q <= StepMaxInit;
      wrap_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStepMin:    step_min_q <= cfg_data_i;
        CfgStepMax:    step_max_q <= cfg_data_i;
        CfgWrapEnable: wrap_q     <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [AngleW-1:0]            lim_lo;
  logic [AngleW-1:0]            lim_hi;
  logic signed [AngleSumW-1:0]  step_sum;
  logic signed [AngleSumW-1:0]  angle_raw;
  logic [AngleW-1:0]            angle_new;
  trig_t                        trig_new;
  logic signed [MotionBits-1:0] other_comp;
  logic signed [ProdW-1:0]      prod_mv;
  logic signed [ProdW-1:0]      prod_other;

  always_comb begin
    lim_lo   = (step_min_q >= FullTurn) ? step_min_q - FullTurn : step_min_q;
    lim_hi   = (step_max_q >= FullTurn) ? step_max_q - FullTurn : step_max_q;
    step_sum = $signed({3'b000, angle_q}) + AngleSumW'(s1_arg_q);

    if (s1_func_q == FuncSetAngle) begin
      angle_raw = AngleSumW'(s1_arg_q);
    end else begin
      angle_raw = step_sum;
      if (s1_arg_q > 0 && step_sum > $signed({3'b000, lim_hi})) begin
        angle_raw = $signed({3'b000, wrap_q ? lim_lo : lim_hi});
      end else if (s1_arg_q < 0 && step_sum < $signed({3'b000, lim_lo})) begin
        angle_raw = $signed({3'b000, wrap_q ? lim_hi : lim_lo});
      end
    end
    angle_new = fold360(angle_raw);
    trig_new  = trig_of(angle_new);

    other_comp = (s1_func_q == FuncMoveX) ? last_y_q : last_x_q;
    prod_mv    = ProdW'(s1_motion_q) * ProdW'(cos_q);
    prod_other = ProdW'(other_comp) * ProdW'(sin_q);

    case (s1_func_q)
      FuncMoveX: begin
        s2_sum_d   = SumW'(prod_mv) - SumW'(prod_other);
        s2_angle_d = angle_q;
      end
      FuncMoveY: begin
        s2_sum_d   = SumW'(prod_other) + SumW'(prod_mv);
        s2_angle_d = angle_q;
      end
      default: begin
        s2_sum_d   = '0;
        s2_angle_d = angle_new;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= '0;
      last_y_q <= '0;
      angle_q  <= '0;
      sin_q    <= '0;
      cos_q    <= TrigW'(1000);
    end else if (s1_adv) begin
      case (s1_func_q)
        FuncMoveX: last_x_q <= s1_motion_q;
        FuncMoveY: last_y_q <= s1_motion_q;
        default: begin
          angle_q <= angle_new;
          sin_q   <= trig_new.sin_v;
          cos_q   <= trig_new.cos_v;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 3 input
  logic                         sum_neg;
  logic [MagW-1:0]              sum_mag;
  logic [MagW+RecW-1:0]         quot_prod;
  logic [QuotW-1:0]             quot_mag;
  logic signed [QuotW:0]        quot_signed;

  always_comb begin
    sum_neg     = s2_sum_q[SumW-1];
    sum_mag     = sum_neg ? MagW'(-s2_sum_q) : MagW'(s2_sum_q);
    // Quotient by 1000, truncated toward zero by working on the magnitude.
    quot_prod   = (MagW+RecW)'(sum_mag) * (MagW+RecW)'(RecipKW);
    quot_mag    = quot_prod[RecShift +: QuotW];
    quot_signed = sum_neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
    motion_out_d = MotionOutW'(quot_signed);
  end

  // ---------------------------------------------------------------- pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q   <= func_e'(func_i);
      s1_motion_q <= motion_i;
      s1_arg_q    <= angle_arg_i;
    end
    if (s1_adv) begin
      s2_sum_q   <= s2_sum_d;
      s2_angle_q <= s2_angle_d;
    end
    if (s2_adv) begin
      motion_out_q <= motion_out_d;
      angle_now_q  <= s2_angle_q;
    end
  end

endmodule

// File: src/mvr_checker.sv
// Port-level checker of the motion vector rotator and its bind statement.
`include "assert_macros.svh"

module mvr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [mvr_pkg::MotionOutW-1:0] motion_out_o,
  input logic [mvr_pkg::AngleW-1:0]            angle_now_o
);
  import mvr_pkg::*;

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(motion_out_o) && $stable(angle_now_o))

  // The input side only backs up when the result waits on a stalled receiver.
  `ASSERT_ALWAYS(a_stall_cause, clk_i, rst_ni, !in_stall_o || (out_valid_o && out_stall_i))

  // The reported angle is always normalised.
  `ASSERT_ALWAYS(a_angle_range, clk_i, rst_ni, !out_valid_o || (angle_now_o < FullTurn))

endmodule

bind motion_vector_rotator_core mvr_checker u_mvr_checker (.*);
